[hw/rtl/mbps_pkg.sv]
// Package for the masked byte pattern scanner.
// Holds sizes, register indexes and the structs shared by the register file,
// the window cells and the top level. Depends on nothing.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;

  localparam int REG_BYTES      = 16;
  localparam int LEN_CAP        = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES
                                                                  : REG_BYTES;
  localparam int LEN_W          = $clog2(LEN_CAP + 1);
  localparam int PAT_IDX_W      = $clog2(REG_BYTES);
  localparam int MATCH_OFFSET_W = 32;

  localparam int NUM_REGS  = 4;
  localparam int DATA_W    = 64;
  localparam int PADDR_W   = $clog2(8 * NUM_REGS);
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_CARE_MASK    = 2'd2,
    REG_PATTERN_LEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
  } cfg_t;

  typedef struct packed {
    logic       active;
    logic       care;
    logic [7:0] pattern;
  } cell_cmp_t;

endpackage

[hw/rtl/mbps_regs.sv]
// Configuration register file of the masked byte pattern scanner.
// An APB-style slave with 64-bit registers at 8-byte spacing.
// Depends on mbps_pkg.
module mbps_regs
  import mbps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.care_mask      <= 16'hFFFF;
      cfg_r.pattern_length <= 5'd1;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_LOW:  cfg_r.pattern_low    <= pwdata;
        REG_PATTERN_HIGH: cfg_r.pattern_high   <= pwdata;
        REG_CARE_MASK:    cfg_r.care_mask      <= pwdata[15:0];
        REG_PATTERN_LEN:  cfg_r.pattern_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LOW:  prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg_r.pattern_high;
      REG_CARE_MASK:    prdata = DATA_W'(cfg_r.care_mask);
      REG_PATTERN_LEN:  prdata = DATA_W'(cfg_r.pattern_length);
      default:          prdata = '0;
    endcase
  end

endmodule

[hw/rtl/mbps_cell.sv]
// One window cell of the masked byte pattern scanner.
// Holds one byte of the sliding window, passes it on to the next cell and
// compares the byte it takes in against its pattern byte. Depends on mbps_pkg.
module mbps_cell
  import mbps_pkg::*;
(
  input  logic      clk,
  input  logic      shift_en,
  input  logic [7:0] byte_in,
  input  cell_cmp_t cmp,
  output logic [7:0] byte_out,
  output logic      hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !cmp.active || !cmp.care || (byte_in == cmp.pattern);

endmodule

[hw/rtl/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner.
// Instantiates mbps_regs and a chain of mbps_cell; depends on mbps_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_data_byte, in_last_byte
//   out      output     out_valid/out_ready  out_found, out_match_offset
//   cfg      input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One byte is taken per cycle; the whole window compare happens in the cycle
// the byte is transferred, and the result is registered for the next cycle.
// The input stalls only while a registered result waits and out_ready is low.
// Reset is synchronous and clears the count, the done flag and the output
// valid; the window cells need no reset.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [MATCH_OFFSET_W-1:0] out_match_offset,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  cfg_t                      cfg;
  logic [7:0]                pat [REG_BYTES];
  logic [LEN_W-1:0]          len_eff;
  logic [7:0]                win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;
  cell_cmp_t                 cmp [MAX_PATTERN_BYTES];

  logic [OFFSET_BITS-1:0]    count_r, count_nxt, count_inc, offset;
  logic                      done_r, done_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [MATCH_OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic                      accept, shift_en, match;

  mbps_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  always_comb begin
    for (int i = 0; i < REG_BYTES; i++) begin
      if (i < 8) begin
        pat[i] = cfg.pattern_low[8*i +: 8];
      end else begin
        pat[i] = cfg.pattern_high[8*(i-8) +: 8];
      end
    end
  end

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > LEN_CAP) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = LEN_W'(cfg.pattern_length);
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign shift_en = accept && !done_r;

  for (genvar w = 0; w < MAX_PATTERN_BYTES; w++) begin : g_cell
    logic [PAT_IDX_W-1:0] j;

    assign j              = PAT_IDX_W'(int'(len_eff) - 1 - w);
    assign cmp[w].active  = int'(len_eff) > w;
    assign cmp[w].care    = cfg.care_mask[j];
    assign cmp[w].pattern = pat[j];

    mbps_cell u_cell (
      .clk     (clk),
      .shift_en(shift_en),
      .byte_in ((w == 0) ? in_data_byte : win[(w == 0) ? 0 : w - 1]),
      .cmp     (cmp[w]),
      .byte_out(win[w]),
      .hit     (hits[w])
    );
  end

  assign count_inc = (count_r == '1) ? count_r : count_r + OFFSET_BITS'(1);
  assign match     = (count_inc >= OFFSET_BITS'(len_eff)) && (&hits);
  assign offset    = count_inc - OFFSET_BITS'(len_eff);

  always_comb begin
    count_nxt      = count_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (accept) begin
      if (done_r) begin
        if (in_last_byte) begin
          count_nxt = '0;
          done_nxt  = 1'b0;
        end
      end else begin
        count_nxt = count_inc;
        if (match) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b1;
          out_offset_nxt = MATCH_OFFSET_W'(offset);
          if (in_last_byte) begin
            count_nxt = '0;
          end else begin
            done_nxt = 1'b1;
          end
        end else if (in_last_byte) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_offset_nxt = '0;
          count_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

endmodule

[tb/tb.sv]
// Self-checking testbench for masked_byte_pattern_scanner: directed table, then random regions.
// A local scan predictor builds the expected outcomes. Depends on mbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb
  import mbps_pkg::*;
();

  localparam int REG_STRIDE = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 450;

  typedef enum logic [1:0] {STEP_BYTE, STEP_REG} step_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FOUND, CHK_MISS} chk_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [7:0]          data;
    logic                last;
    chk_t                chk;
    logic [31:0]         off;
    reg_idx_t            idx;
    logic [DATA_W-1:0]   value;
  } step_t;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } scan_outcome_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_data_byte = '0;
  logic                      in_last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_found;
  logic [MATCH_OFFSET_W-1:0] out_match_offset;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  masked_byte_pattern_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0]            pat_lo;
  logic [63:0]            pat_hi;
  logic [15:0]            care;
  logic [4:0]             plen;
  logic [7:0]             win [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] seen;
  bit                     matched;

  scan_outcome_t scan_outcomes[$];
  step_t         plan[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int n_found = 0;
  int n_missed = 0;
  int regions = 0;
  int phases = 0;
  int burst_left = 0;
  int rx_left = 0;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_open = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int active_len();
    if (plen == 0) return 1;
    if (plen > LEN_CAP) return LEN_CAP;
    return int'(plen);
  endfunction

  function automatic logic [7:0] pattern_at(input int j);
    return (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
  endfunction

  function automatic bit window_hit(input int n);
    for (int j = 0; j < n; j++) begin
      if (care[j] && win[n-1-j] != pattern_at(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic restart_scan();
    foreach (win[k]) win[k] = '0;
    seen = '0;
    matched = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last, output bit hit,
                           output scan_outcome_t res);
    int n;
    hit = 1'b0;
    res = '0;
    if (matched) begin
      if (last) restart_scan();
      return;
    end
    for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (seen != '1) seen++;
    n = active_len();
    if (seen >= n && window_hit(n)) begin
      hit = 1'b1;
      res.found = 1'b1;
      res.offset = MATCH_OFFSET_W'(seen - n);
      if (last) restart_scan();
      else matched = 1'b1;
    end else if (last) begin
      hit = 1'b1;
      restart_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_open) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= !out_ready;
      rx_left <= out_ready ? $urandom_range(0, 19) : $urandom_range(0, 9);
    end
  end

  always @(posedge clk) begin : check_results
    scan_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scan_outcomes.size() == 0) begin
        report_mismatch("result with none pending", out_match_offset, '0);
      end else begin
        want = scan_outcomes.pop_front();
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_match_offset !== want.offset)
          report_mismatch("match_offset", out_match_offset, want.offset);
      end
      if (out_found) n_found++;
      else n_missed++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last, input chk_t chk,
                           input logic [31:0] off);
    bit            hit;
    scan_outcome_t res;
    if (!tx_steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    scan_byte(data, last, hit, res);
    case (chk)
      CHK_MODEL: if (hit) scan_outcomes.push_back(res);
      CHK_FOUND: begin
        res.found = 1'b1;
        res.offset = off;
        scan_outcomes.push_back(res);
      end
      CHK_MISS: begin
        res = '0;
        scan_outcomes.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (scan_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_STRIDE * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PATTERN_LOW: begin
        pat_lo = value;
        want = value;
      end
      REG_PATTERN_HIGH: begin
        pat_hi = value;
        want = value;
      end
      REG_CARE_MASK: begin
        care = value[15:0];
        want = DATA_W'(value[15:0]);
      end
      default: begin
        plen = value[4:0];
        want = DATA_W'(value[4:0]);
      end
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] d, input logic l, input chk_t c,
                                   input logic [31:0] o);
    step_t s;
    s = '0;
    s.kind = STEP_BYTE;
    s.data = d;
    s.last = l;
    s.chk = c;
    s.off = o;
    plan.push_back(s);
  endfunction

  function automatic void add_reg(input reg_idx_t i, input logic [DATA_W-1:0] v);
    step_t s;
    s = '0;
    s.kind = STEP_REG;
    s.idx = i;
    s.value = v;
    plan.push_back(s);
  endfunction

  task automatic new_setting();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] mask;
    logic [4:0]  len;
    int          pick;
    settle();
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_open = ($urandom_range(0, 3) == 0);
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    mask = 16'($urandom());
    len = 5'($urandom_range(1, 8));
    case (phases)
      0: begin
        lo = '1;
        hi = '1;
        mask = '1;
        len = 5'(LEN_CAP);
      end
      1: begin
        mask = '0;
        len = '1;
      end
      2: begin
        lo = '0;
        len = 5'd1;
      end
      default: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) lo = '0;
        if (pick == 1) hi = '1;
        pick = $urandom_range(0, 5);
        if (pick == 0) mask = '0;
        if (pick == 1) mask = '1;
        pick = $urandom_range(0, 9);
        if (pick == 0) len = '0;
        else if (pick == 1) len = 5'($urandom_range(LEN_CAP + 1, 31));
        else if (pick == 2) len = 5'(LEN_CAP);
        else if (pick < 6) len = 5'($urandom_range(9, LEN_CAP));
      end
    endcase
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {$urandom(), 16'($urandom()), mask});
    write_reg(REG_PATTERN_LEN, {$urandom(), 27'($urandom()), len});
    phases++;
  endtask

  task automatic run_region();
    logic [7:0] body[$];
    int         rlen;
    int         pos;
    int         n;
    bit         embed;
    n = active_len();
    rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    embed = ($urandom_range(0, 9) < 6);
    if (embed && rlen < n && $urandom_range(0, 4) != 0) rlen = n + $urandom_range(0, 8);
    for (int i = 0; i < rlen; i++) begin
      if ($urandom_range(0, 1) != 0) body.push_back(pattern_at($urandom_range(0, n - 1)));
      else body.push_back(8'($urandom()));
    end
    if (embed) begin
      pos = $urandom_range(0, rlen - 1);
      if (rlen >= n && $urandom_range(0, 4) != 0) pos = $urandom_range(0, rlen - n);
      for (int j = 0; j < n; j++) begin
        if (pos + j < rlen && care[j]) body[pos+j] = pattern_at(j);
      end
    end
    for (int i = 0; i < rlen; i++) send_byte(body[i], i == rlen - 1, CHK_MODEL, '0);
    regions++;
  endtask

  initial begin : stimulus
    int random_start;
    pat_lo = '0;
    pat_hi = '0;
    care = '1;
    plen = 5'd1;
    restart_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_byte(8'h00, 1'b0, CHK_FOUND, 32'd0);
    add_byte(8'hFF, 1'b0, CHK_NONE, '0);
    add_byte(8'h00, 1'b1, CHK_NONE, '0);
    add_byte(8'hFF, 1'b1, CHK_MISS, '0);
    add_reg(REG_PATTERN_LOW, 64'h0000_0000_FF00_3412);
    add_reg(REG_PATTERN_LEN, 64'd4);
    add_byte(8'h55, 1'b0, CHK_NONE, '0);
    add_byte(8'h12, 1'b0, CHK_NONE, '0);
    add_byte(8'h34, 1'b0, CHK_NONE, '0);
    add_byte(8'h00, 1'b0, CHK_NONE, '0);
    add_byte(8'hFF, 1'b1, CHK_FOUND, 32'd1);
    add_byte(8'h12, 1'b0, CHK_NONE, '0);
    add_byte(8'h34, 1'b1, CHK_MISS, '0);
    add_reg(REG_CARE_MASK, 64'hFFFB);
    add_byte(8'h12, 1'b0, CHK_MODEL, '0);
    add_byte(8'h34, 1'b0, CHK_MODEL, '0);
    add_byte(8'hA5, 1'b0, CHK_MODEL, '0);
    add_byte(8'hFF, 1'b0, CHK_MODEL, '0);
    add_byte(8'h00, 1'b1, CHK_MODEL, '0);
    add_reg(REG_PATTERN_LEN, 64'd0);
    add_byte(8'hFE, 1'b0, CHK_NONE, '0);
    add_reg(REG_PATTERN_LOW, 64'h12FE);
    add_reg(REG_PATTERN_LEN, 64'd2);
    add_byte(8'h12, 1'b1, CHK_FOUND, 32'd0);
    add_reg(REG_PATTERN_LEN, 64'd0);
    add_byte(8'hFE, 1'b1, CHK_FOUND, 32'd0);
    add_byte(8'h00, 1'b1, CHK_MISS, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_byte(plan[i].data, plan[i].last, plan[i].chk, plan[i].off);
      end
    end

    random_start = bytes_sent;
    settle();
    while (bytes_sent - random_start < RANDOM_ITEMS) begin
      new_setting();
      repeat ($urandom_range(3, 6)) begin
        run_region();
        if ($urandom_range(0, 5) == 0) settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d bytes: %0d random regions under %0d register settings.",
             bytes_sent, regions, phases);
    $display("Checked %0d match reports and %0d not-found reports; %0d mismatches.",
             n_found, n_missed, mismatches);
    if (mismatches == 0 && scan_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_regs.sv
hw/rtl/mbps_cell.sv
hw/rtl/masked_byte_pattern_scanner.sv
tb/tb.sv
